/* src/sqt_pkg.sv */
package sqt_pkg;

  localparam int PositionBits = 16;
  localparam int FieldBits = 16;
  localparam int MaxToks = 3;
  localparam int QDepth = 2;
  localparam int NumKeywords = 6;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_WORD   = 3'd1,
    MODE_NUMBER = 3'd2,
    MODE_GT     = 3'd3,
    MODE_LT     = 3'd4,
    MODE_BANG   = 3'd5,
    MODE_STRING = 3'd6
  } mode_e;

  typedef enum logic [4:0] {
    TOK_SELECT = 5'd0,
    TOK_FROM   = 5'd1,
    TOK_WHERE  = 5'd2,
    TOK_ORDER  = 5'd3,
    TOK_BY     = 5'd4,
    TOK_GROUP  = 5'd5,
    TOK_IDENT  = 5'd6,
    TOK_INT    = 5'd7,
    TOK_FLOAT  = 5'd8,
    TOK_GT     = 5'd9,
    TOK_GTE    = 5'd10,
    TOK_LT     = 5'd11,
    TOK_LTE    = 5'd12,
    TOK_EQ     = 5'd13,
    TOK_NEQ    = 5'd14,
    TOK_COMMA  = 5'd15,
    TOK_SEMI   = 5'd16,
    TOK_LPAREN = 5'd17,
    TOK_RPAREN = 5'd18,
    TOK_STRING = 5'd19,
    TOK_END    = 5'd20,
    TOK_ERROR  = 5'd21
  } tok_kind_e;

  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_QUOTE  = 8'h27;

  localparam logic [NumKeywords-1:0][47:0] KwBits = {
    48'h000047524F5550,
    48'h00000000004259,
    48'h0000004F524445 << 8 | 48'h52,
    48'h00005748455245,
    48'h00000046524F4D,
    48'h53454C454354
  };

  localparam logic [NumKeywords-1:0][2:0] KwLen = {
    3'd5, 3'd2, 3'd5, 3'd5, 3'd4, 3'd6
  };

  typedef struct packed {
    tok_kind_e              kind;
    logic [FieldBits-1:0]   start;
    logic [FieldBits-1:0]   len;
  } tok_t;

  typedef struct packed {
    tok_t [MaxToks-1:0] toks;
    logic [1:0]         cnt;
  } group_t;

  function automatic tok_kind_e word_kind(logic [47:0] chars, logic [2:0] cnt);
    tok_kind_e k;
    k = TOK_IDENT;
    for (int i = 0; i < NumKeywords; i++) begin
      if (cnt == KwLen[i] && chars == KwBits[i]) begin
        k = tok_kind_e'(5'(i));
      end
    end
    return k;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

/* src/sqt_lexer.sv */
module sqt_lexer #(
  parameter int PositionBits = sqt_pkg::PositionBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [7:0]      char_i,
  input  logic            present_i,
  input  logic            end_i,
  output logic            push_o,
  output sqt_pkg::group_t group_o,
  input  logic            full_i
);

  localparam logic [PositionBits-1:0] PosMax = '1;

  sqt_pkg::mode_e          mode_q, mode_d, mode_b;
  logic [47:0]             chars_q, chars_d, chars_b;
  logic [2:0]              wcnt_q, wcnt_d, wcnt_b;
  logic                    dot_q, dot_d, dot_b;
  logic [PositionBits-1:0] start_q, start_d, start_b;
  logic [PositionBits-1:0] pos_q, pos_d, pos_b;
  logic                    absorb;
  logic                    is_mark;
  sqt_pkg::tok_kind_e      mark_kind;
  sqt_pkg::group_t         grp;
  logic                    accept;

  function automatic logic [sqt_pkg::FieldBits-1:0] fit(logic [PositionBits-1:0] v);
    logic [PositionBits+sqt_pkg::FieldBits-1:0] e;
    e = {{sqt_pkg::FieldBits{1'b0}}, v};
    return e[sqt_pkg::FieldBits-1:0];
  endfunction

  function automatic logic [sqt_pkg::FieldBits-1:0] span(logic [PositionBits-1:0] p,
                                                         logic [PositionBits-1:0] s);
    return (p >= s) ? fit(p - s) : '0;
  endfunction

  function automatic sqt_pkg::tok_t mk(sqt_pkg::tok_kind_e k, logic [PositionBits-1:0] s,
                                       logic [sqt_pkg::FieldBits-1:0] l);
    sqt_pkg::tok_t t;
    t.kind  = k;
    t.start = fit(s);
    t.len   = l;
    return t;
  endfunction

  function automatic logic pending(sqt_pkg::mode_e m);
    return m == sqt_pkg::MODE_WORD || m == sqt_pkg::MODE_NUMBER ||
           m == sqt_pkg::MODE_GT || m == sqt_pkg::MODE_LT;
  endfunction

  function automatic sqt_pkg::tok_t flush_tok(sqt_pkg::mode_e m, logic [47:0] ch,
                                              logic [2:0] wc, logic dt,
                                              logic [PositionBits-1:0] s,
                                              logic [PositionBits-1:0] p);
    sqt_pkg::tok_t t;
    unique case (m)
      sqt_pkg::MODE_WORD:   t = mk(sqt_pkg::word_kind(ch, wc), s, span(p, s));
      sqt_pkg::MODE_NUMBER: t = mk(dt ? sqt_pkg::TOK_FLOAT : sqt_pkg::TOK_INT, s, span(p, s));
      sqt_pkg::MODE_GT:     t = mk(sqt_pkg::TOK_GT, s, sqt_pkg::FieldBits'(1));
      default:              t = mk(sqt_pkg::TOK_LT, s, sqt_pkg::FieldBits'(1));
    endcase
    return t;
  endfunction

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  // A byte that continues the token in progress is absorbed by it.
  always_comb begin : absorb_dec
    unique case (mode_q) inside
      sqt_pkg::MODE_WORD: begin
        absorb = sqt_pkg::is_alpha(char_i);
      end
      sqt_pkg::MODE_NUMBER: begin
        absorb = sqt_pkg::is_digit(char_i) || char_i == sqt_pkg::CH_DOT;
      end
      sqt_pkg::MODE_GT, sqt_pkg::MODE_LT, sqt_pkg::MODE_BANG: begin
        absorb = char_i == sqt_pkg::CH_EQ;
      end
      sqt_pkg::MODE_STRING: begin
        absorb = 1'b1;
      end
      default: begin
        absorb = 1'b0;
      end
    endcase
  end

  always_comb begin : mark_dec
    is_mark   = 1'b1;
    mark_kind = sqt_pkg::TOK_EQ;
    unique case (char_i)
      sqt_pkg::CH_EQ:     mark_kind = sqt_pkg::TOK_EQ;
      sqt_pkg::CH_COMMA:  mark_kind = sqt_pkg::TOK_COMMA;
      sqt_pkg::CH_SEMI:   mark_kind = sqt_pkg::TOK_SEMI;
      sqt_pkg::CH_LPAREN: mark_kind = sqt_pkg::TOK_LPAREN;
      sqt_pkg::CH_RPAREN: mark_kind = sqt_pkg::TOK_RPAREN;
      default:            is_mark   = 1'b0;
    endcase
  end

  // State after the byte of the beat; the end mark then clears it.
  always_comb begin : next_state
    mode_b  = mode_q;
    chars_b = chars_q;
    wcnt_b  = wcnt_q;
    dot_b   = dot_q;
    start_b = start_q;
    pos_b   = pos_q;
    if (present_i) begin
      if (absorb) begin
        unique case (mode_q) inside
          sqt_pkg::MODE_WORD: begin
            if (wcnt_q < 3'd6) begin
              chars_b = {chars_q[39:0], char_i};
            end
            if (wcnt_q < 3'd7) begin
              wcnt_b = wcnt_q + 3'd1;
            end
          end
          sqt_pkg::MODE_NUMBER: begin
            if (char_i == sqt_pkg::CH_DOT) begin
              dot_b = 1'b1;
            end
          end
          sqt_pkg::MODE_STRING: begin
            if (char_i == sqt_pkg::CH_QUOTE) begin
              mode_b = sqt_pkg::MODE_IDLE;
            end
          end
          default: begin
            mode_b = sqt_pkg::MODE_IDLE;
          end
        endcase
      end else begin
        mode_b  = sqt_pkg::MODE_IDLE;
        start_b = pos_q;
        if (sqt_pkg::is_alpha(char_i)) begin
          mode_b  = sqt_pkg::MODE_WORD;
          chars_b = {40'b0, char_i};
          wcnt_b  = 3'd1;
        end else if (sqt_pkg::is_digit(char_i)) begin
          mode_b = sqt_pkg::MODE_NUMBER;
          dot_b  = 1'b0;
        end else if (char_i == sqt_pkg::CH_GT) begin
          mode_b = sqt_pkg::MODE_GT;
        end else if (char_i == sqt_pkg::CH_LT) begin
          mode_b = sqt_pkg::MODE_LT;
        end else if (char_i == sqt_pkg::CH_BANG) begin
          mode_b = sqt_pkg::MODE_BANG;
        end else if (char_i == sqt_pkg::CH_QUOTE) begin
          mode_b  = sqt_pkg::MODE_STRING;
          start_b = (pos_q < PosMax) ? pos_q + 1'b1 : pos_q;
        end
      end
      if (pos_q < PosMax) begin
        pos_b = pos_q + 1'b1;
      end
    end
  end

  assign mode_d  = end_i ? sqt_pkg::MODE_IDLE : mode_b;
  assign chars_d = end_i ? '0 : chars_b;
  assign wcnt_d  = end_i ? '0 : wcnt_b;
  assign dot_d   = end_i ? 1'b0 : dot_b;
  assign start_d = end_i ? '0 : start_b;
  assign pos_d   = end_i ? '0 : pos_b;

  always_comb begin : tokens
    logic [1:0] n;
    n   = '0;
    grp = '0;
    if (present_i) begin
      if (absorb) begin
        if (mode_q == sqt_pkg::MODE_STRING) begin
          if (char_i == sqt_pkg::CH_QUOTE) begin
            grp.toks[n] = mk(sqt_pkg::TOK_STRING, start_q, span(pos_q, start_q));
            n = n + 2'd1;
          end
        end else if (mode_q inside {sqt_pkg::MODE_GT, sqt_pkg::MODE_LT,
                                    sqt_pkg::MODE_BANG}) begin
          grp.toks[n] = mk((mode_q == sqt_pkg::MODE_GT) ? sqt_pkg::TOK_GTE :
                           (mode_q == sqt_pkg::MODE_LT) ? sqt_pkg::TOK_LTE :
                           sqt_pkg::TOK_NEQ, start_q, sqt_pkg::FieldBits'(2));
          n = n + 2'd1;
        end
      end else begin
        if (pending(mode_q)) begin
          grp.toks[n] = flush_tok(mode_q, chars_q, wcnt_q, dot_q, start_q, pos_q);
          n = n + 2'd1;
        end
        if (is_mark) begin
          grp.toks[n] = mk(mark_kind, pos_q, sqt_pkg::FieldBits'(1));
          n = n + 2'd1;
        end
      end
    end
    if (end_i) begin
      if (mode_b == sqt_pkg::MODE_STRING) begin
        grp.toks[n] = mk(sqt_pkg::TOK_ERROR, start_b, span(pos_b, start_b));
        n = n + 2'd1;
      end else begin
        if (pending(mode_b)) begin
          grp.toks[n] = flush_tok(mode_b, chars_b, wcnt_b, dot_b, start_b, pos_b);
          n = n + 2'd1;
        end
        grp.toks[n] = mk(sqt_pkg::TOK_END, pos_b, '0);
        n = n + 2'd1;
      end
    end
    grp.cnt = n;
  end

  assign push_o  = accept && (grp.cnt != 2'd0);
  assign group_o = grp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= sqt_pkg::MODE_IDLE;
      chars_q <= '0;
      wcnt_q  <= '0;
      dot_q   <= 1'b0;
      start_q <= '0;
      pos_q   <= '0;
    end else if (accept) begin
      mode_q  <= mode_d;
      chars_q <= chars_d;
      wcnt_q  <= wcnt_d;
      dot_q   <= dot_d;
      start_q <= start_d;
      pos_q   <= pos_d;
    end
  end

endmodule

/* src/sqt_queue.sv */
module sqt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sqt_pkg::group_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output sqt_pkg::group_t data_o
);

  localparam int PtrBits = (sqt_pkg::QDepth > 1) ? $clog2(sqt_pkg::QDepth) : 1;
  localparam logic [PtrBits-1:0] LastPtr = PtrBits'(sqt_pkg::QDepth - 1);

  sqt_pkg::group_t    mem_q [sqt_pkg::QDepth];
  logic [PtrBits-1:0] wr_q, rd_q;
  logic [PtrBits:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = cnt_q == (PtrBits+1)'(sqt_pkg::QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/sqt_emitter.sv */
module sqt_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  sqt_pkg::group_t group_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output sqt_pkg::tok_t   tok_o,
  output logic            last_o
);

  logic [1:0] idx_q, idx_d;
  logic       fire;

  assign valid_o = !empty_i;
  assign tok_o   = group_i.toks[idx_q];
  assign last_o  = idx_q == (group_i.cnt - 2'd1);
  assign fire    = valid_o && ready_i;
  assign pop_o   = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

/* src/sql_query_tokenizer.sv */
// Streaming SQL lexer. One input beat (a text byte, an end mark, or both) is
// accepted per clock while the two-group queue between lexer and emitter has
// room; each beat yields zero to three tokens, and each token leaves as one
// output beat, so sustained throughput is one item per cycle when items
// average one token or fewer and the output is ready. A token is registered in
// the queue before it appears on the output. Positions count from zero per
// statement and saturate at 2^PositionBits-1; output offsets and lengths carry
// their low 16 bits.
module sql_query_tokenizer #(
  parameter int PositionBits = sqt_pkg::PositionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // char_code
  input  logic        s_axis_tuser,   // char_present
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // token_length (31:16), token_start (15:0)
  output logic [4:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast
);

  logic            push, full, pop, empty;
  sqt_pkg::group_t grp_in, grp_out;
  sqt_pkg::tok_t   tok;

  sqt_lexer #(.PositionBits(PositionBits)) u_lexer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .char_i     (s_axis_tdata),
    .present_i  (s_axis_tuser),
    .end_i      (s_axis_tlast),
    .push_o     (push),
    .group_o    (grp_in),
    .full_i     (full)
  );

  sqt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (grp_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (grp_out)
  );

  sqt_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .group_i (grp_out),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .tok_o   (tok),
    .last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {tok.len, tok.start};
  assign m_axis_tuser = tok.kind;

endmodule

/* src/sqt_checker.sv */
module sqt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [4:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic [4:0]  kind;
  logic [15:0] len;
  assign kind = m_axis_tuser;
  assign len  = m_axis_tdata[31:16];

  // A stalled output beat must stay offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat withdrawn while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> kind <= 5'(sqt_pkg::TOK_ERROR))
    else $error("token kind out of range");

  // End and error tokens close the statement and are always the final token of their group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == 5'(sqt_pkg::TOK_END) || kind == 5'(sqt_pkg::TOK_ERROR))
    |-> m_axis_tlast)
    else $error("end of statement token not last of its run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && kind == 5'(sqt_pkg::TOK_END) |-> len == 16'd0)
    else $error("end token with nonzero length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (kind == 5'(sqt_pkg::TOK_GTE) || kind == 5'(sqt_pkg::TOK_LTE) ||
                      kind == 5'(sqt_pkg::TOK_NEQ))
    |-> len == 16'd2)
    else $error("two-byte operator with wrong length");

endmodule

bind sql_query_tokenizer sqt_checker u_sqt_checker (.*);
